// ===== rtl/mlae_pkg.sv =====
// Shared types and constants for the MADT local APIC enumerator.
// Used by the parser, the result queue and the top level; depends on nothing.
package mlae_pkg;

  localparam logic [7:0] MAX_CPUS_RESET = 8'd255;

  localparam logic [7:0] REC_LOCAL_APIC   = 8'd0;
  localparam logic [7:0] REC_LOCAL_X2APIC = 8'd9;

  localparam logic [7:0] LAPIC_MIN_LEN  = 8'd8;
  localparam logic [7:0] X2APIC_MIN_LEN = 8'd16;
  localparam logic [7:0] REC_MIN_LEN    = 8'd2;

  localparam logic [7:0] POS_TYPE       = 8'd0;
  localparam logic [7:0] POS_LENGTH     = 8'd1;
  localparam logic [7:0] POS_LAPIC_ID   = 8'd3;
  localparam logic [7:0] POS_FLAGS      = 8'd4;
  localparam logic [7:0] POS_X2_ID_LOW  = 8'd8;
  localparam logic [7:0] POS_X2_ID_HIGH = 8'd11;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic       is_summary;
    logic [7:0] apic_id;
    logic [7:0] cpu_index;
    logic [7:0] cpu_count;
    logic [7:0] bsp_apic_id;
    logic       status;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic       push;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== rtl/mlae_parser.sv =====
// Record walker for the MADT body: holds the parse state and forms the
// results caused by one byte. Depends on mlae_pkg.
module mlae_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic [7:0]      max_cpus,
  output mlae_pkg::push_t push_out
);

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] record_type, record_type_next;
  logic [7:0] record_length, record_length_next;
  logic       enabled_flag, enabled_flag_next;
  logic [7:0] captured_id, captured_id_next;
  logic       id_too_large, id_too_large_next;
  logic [7:0] found_count, found_count_next;
  logic [7:0] first_id, first_id_next;
  logic       parse_stopped, parse_stopped_next;
  logic       emit;
  logic       rec_ok;
  mlae_pkg::result_t entry_res, summary_res;

  always_comb begin
    byte_position_next = byte_position;
    record_type_next   = record_type;
    record_length_next = record_length;
    enabled_flag_next  = enabled_flag;
    captured_id_next   = captured_id;
    id_too_large_next  = id_too_large;
    found_count_next   = found_count;
    first_id_next      = first_id;
    parse_stopped_next = parse_stopped;
    emit               = 1'b0;
    rec_ok             = 1'b0;

    if (!parse_stopped) begin
      if (byte_position == mlae_pkg::POS_TYPE) begin
        record_type_next  = data_byte;
        enabled_flag_next = 1'b0;
        captured_id_next  = 8'd0;
        id_too_large_next = 1'b0;
      end else if (byte_position == mlae_pkg::POS_LENGTH) begin
        record_length_next = data_byte;
        if (data_byte < mlae_pkg::REC_MIN_LEN) begin
          parse_stopped_next = 1'b1;
        end
      end else begin
        if (record_type == mlae_pkg::REC_LOCAL_APIC &&
            byte_position == mlae_pkg::POS_LAPIC_ID) begin
          captured_id_next = data_byte;
        end
        if (byte_position == mlae_pkg::POS_FLAGS) begin
          enabled_flag_next = data_byte[0];
        end
        if (record_type == mlae_pkg::REC_LOCAL_X2APIC) begin
          if (byte_position == mlae_pkg::POS_X2_ID_LOW) begin
            captured_id_next = data_byte;
          end
          if (byte_position > mlae_pkg::POS_X2_ID_LOW &&
              byte_position <= mlae_pkg::POS_X2_ID_HIGH && data_byte != 8'd0) begin
            id_too_large_next = 1'b1;
          end
        end
      end

      if (!parse_stopped_next) begin
        if (byte_position != mlae_pkg::POS_TYPE &&
            ({1'b0, byte_position} + 9'd1) == {1'b0, record_length_next}) begin
          if (record_type_next == mlae_pkg::REC_LOCAL_APIC &&
              record_length_next >= mlae_pkg::LAPIC_MIN_LEN) begin
            rec_ok = 1'b1;
          end
          if (record_type_next == mlae_pkg::REC_LOCAL_X2APIC &&
              record_length_next >= mlae_pkg::X2APIC_MIN_LEN && !id_too_large_next) begin
            rec_ok = 1'b1;
          end
          if (rec_ok && enabled_flag_next && found_count < max_cpus) begin
            emit             = 1'b1;
            found_count_next = found_count + 8'd1;
            if (found_count == 8'd0) begin
              first_id_next = captured_id_next;
            end
          end
          byte_position_next = 8'd0;
        end else begin
          byte_position_next = byte_position + 8'd1;
        end
      end
    end

    entry_res             = '0;
    entry_res.apic_id     = captured_id_next;
    entry_res.cpu_index   = found_count;
    entry_res.last_result = !last_byte;

    summary_res             = '0;
    summary_res.is_summary  = 1'b1;
    summary_res.cpu_count   = found_count_next;
    summary_res.bsp_apic_id = (found_count_next != 8'd0) ? first_id_next : 8'd0;
    summary_res.status      = (found_count_next == 8'd0);
    summary_res.last_result = 1'b1;

    push_out.push   = accept;
    push_out.count  = {1'b0, emit} + {1'b0, last_byte};
    push_out.first  = emit ? entry_res : summary_res;
    push_out.second = summary_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      record_type   <= '0;
      record_length <= '0;
      enabled_flag  <= 1'b0;
      captured_id   <= '0;
      id_too_large  <= 1'b0;
      found_count   <= '0;
      first_id      <= '0;
      parse_stopped <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position <= '0;
        record_type   <= '0;
        record_length <= '0;
        enabled_flag  <= 1'b0;
        captured_id   <= '0;
        id_too_large  <= 1'b0;
        found_count   <= '0;
        first_id      <= '0;
        parse_stopped <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        record_type   <= record_type_next;
        record_length <= record_length_next;
        enabled_flag  <= enabled_flag_next;
        captured_id   <= captured_id_next;
        id_too_large  <= id_too_large_next;
        found_count   <= found_count_next;
        first_id      <= first_id_next;
        parse_stopped <= parse_stopped_next;
      end
    end
  end

endmodule

// ===== rtl/mlae_out_queue.sv =====
// Two-slot result queue between the parser and the output channel.
// Takes up to two results per beat. Depends on mlae_pkg.
module mlae_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  mlae_pkg::push_t   push_in,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output mlae_pkg::result_t out_res
);

  mlae_pkg::result_t slot0, slot1, slot0_next, slot1_next;
  logic [1:0] count, count_next;
  logic [1:0] kept;
  logic [1:0] push_cnt;
  logic       pop;

  assign pop      = (count != 2'd0) && out_ready;
  assign kept     = count - {1'b0, pop};
  assign push_cnt = push_in.push ? push_in.count : 2'd0;
  assign space_ok = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    count_next = kept + push_cnt;
    if (pop) begin
      slot0_next = slot1;
    end
    if (push_in.push) begin
      case (kept)
        2'd0: begin
          slot0_next = push_in.first;
          slot1_next = push_in.second;
        end
        2'd1: begin
          slot1_next = push_in.first;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign out_valid = (count != 2'd0);
  assign out_res   = slot0;

endmodule

// ===== rtl/madt_local_apic_enumerator_core.sv =====
// Top level of the MADT local APIC enumerator: configuration register and
// stream ports. Depends on mlae_pkg, mlae_parser and mlae_out_queue.
//
// The slave stream carries the MADT body after its 44-byte header, one byte
// per beat, with s_tlast on the table's final byte. The master stream gives
// one beat per enabled CPU entry, up to max_cpus (m_tuser low), and after
// the final byte one summary beat (m_tuser high); m_tlast marks the last
// result that an input byte caused. A byte's first result is on the master
// side in the cycle after the byte is accepted. One byte is accepted per
// cycle while results drain; a byte that completes an entry on the final
// byte gives two results, which stall the input while the two-slot queue
// is full. When the receiver stalls, at most two results wait in the queue
// and s_tready drops until there is room. The cfg channel writes max_cpus
// and is always ready. Reset empties the queue, clears the parse state and
// sets max_cpus to 255; after each summary the parse state clears itself.
module madt_local_apic_enumerator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [mlae_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tdata: [7:0] apic_id, [15:8] cpu_index, [23:16] cpu_count,
  // [31:24] bsp_apic_id, [32] status, [39:33] zero
  output logic        m_tuser,   // [0] is_summary
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]        max_cpus;
  logic              accept;
  mlae_pkg::push_t   push;
  mlae_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cpus <= mlae_pkg::MAX_CPUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_cpus <= cfg_data;
    end
  end

  assign accept = s_tvalid && s_tready;

  mlae_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .max_cpus  (max_cpus),
    .push_out  (push)
  );

  mlae_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_in   (push),
    .space_ok  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {7'd0, res.status, res.bsp_apic_id, res.cpu_count,
                    res.cpu_index, res.apic_id};
  assign m_tuser = res.is_summary;
  assign m_tlast = res.last_result;

endmodule
